FILE: rtl/block_reverse_stream_unit_defines.svh
// assertion macros for the block reverse stream unit
`ifndef BLOCK_REVERSE_STREAM_UNIT_DEFINES_SVH
`define BLOCK_REVERSE_STREAM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define BRS_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
// antecedent in one cycle implies consequent in the next
`define BRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BRS_ASSERT(lbl, expr)
`define BRS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/brs_pkg.sv
package brs_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = 5'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     end_of_list;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    logic                     last_of_run;
    logic                     list_done;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input transfer taken this cycle
    logic rd_en;    // read buffer at current pointer
    logic load;     // move read data into output register
    logic advance;  // step pointer to next entry
  } brs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;     // accepted item causes results
    logic last;     // current entry is the last of the run
    logic out_free; // output register can take a word this cycle
  } brs_sts_t;

endpackage

FILE: rtl/brs_ctrl.sv
module brs_ctrl
  import brs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  brs_sts_t sts_i,
  output brs_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.emit) state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_HOLD;
      end
      ST_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

FILE: rtl/brs_datapath.sv
module brs_datapath
  import brs_pkg::*;
#(
  parameter int MAX_GROUP = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  in_item_t         in_data_i,
  output out_item_t        out_data_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  brs_cmd_t         cmd_i,
  output brs_sts_t         sts_o
);

  localparam int AddrW = $clog2(MAX_GROUP);
  localparam int KW    = (AddrW + 1 > CFG_W) ? AddrW + 1 : CFG_W;

  logic [CFG_W-1:0]  block_size_q;
  logic [AddrW-1:0]  fill_q;
  logic [AddrW-1:0]  ptr_q;
  logic [AddrW-1:0]  remain_q;
  logic              down_q;
  logic              eol_q;
  logic              out_valid_q;

  logic [DATA_W-1:0] mem [MAX_GROUP];
  logic [DATA_W-1:0] rd_data_q;
  out_item_t         out_q;

  logic [KW-1:0] bs_ext, k_eff, n_ext;
  logic          pass, full;

  // effective group length, oversized values clamp to the buffer depth
  always_comb begin
    bs_ext = KW'(block_size_q);
    k_eff  = (bs_ext > KW'(MAX_GROUP)) ? KW'(MAX_GROUP) : bs_ext;
    n_ext  = KW'(fill_q) + KW'(1);
    pass   = (k_eff <= KW'(1));
    full   = (n_ext >= k_eff);
  end

  assign sts_o.emit     = pass | full | in_data_i.end_of_list;
  assign sts_o.last     = (remain_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BLOCK_SIZE_RESET;
      fill_q       <= '0;
      ptr_q        <= '0;
      remain_q     <= '0;
      down_q       <= 1'b0;
      eol_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) block_size_q <= cfg_data_i;
      if (cmd_i.accept) begin
        eol_q <= in_data_i.end_of_list;
        if (sts_o.emit) begin
          fill_q   <= '0;
          remain_q <= fill_q;
          down_q   <= !pass && full;
          ptr_q    <= (!pass && full) ? fill_q : '0;
        end else begin
          fill_q <= fill_q + AddrW'(1);
        end
      end
      if (cmd_i.advance) begin
        remain_q <= remain_q - AddrW'(1);
        ptr_q    <= down_q ? ptr_q - AddrW'(1) : ptr_q + AddrW'(1);
      end
      if (cmd_i.load)       out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // group buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) mem[fill_q] <= in_data_i.value;
    if (cmd_i.rd_en)  rd_data_q   <= mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.value_out   <= rd_data_q;
      out_q.last_of_run <= sts_o.last;
      out_q.list_done   <= sts_o.last && eol_q;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/block_reverse_stream_unit.sv
// path: an item that closes a run is written to the group buffer, the first entry of the run is
//   read into the read register, then loaded into the output register once that is free; the
//   sequencer alternates a buffer read and an output load for every result and blocks the
//   input until the run is done, while an item that only fills the buffer leaves it open
// reset: control state and fill count clear, block_size returns to 2, the group
//   buffer keeps its contents and needs no clearing pass
`include "block_reverse_stream_unit_defines.svh"

module block_reverse_stream_unit
  import brs_pkg::*;
#(
  parameter int MAX_GROUP = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration, group length
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  // input words
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  // reordered words
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  // command and status between sequencer and datapath
  brs_cmd_t cmd;
  brs_sts_t sts;

  // sequencer: takes a transfer when idle, then walks the buffer one entry per
  // read and load pair until the last entry of the run is in the output register
  brs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: group buffer, fill count, read pointer and the output register,
  // which lets a new input transfer in while the last result still waits
  brs_datapath #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // a transfer that opens a run blocks the input until the run is done
  `BRS_ASSERT_NEXT(a_run_blocks_input, in_valid_i && !in_stall_o && sts.emit, in_stall_o)
  // the output register is never overwritten while a word in it is stalled
  `BRS_ASSERT(a_no_overwrite, !(cmd.load && out_valid_o && out_stall_i))
  // end of list only ever marks the last word of a run
  `BRS_ASSERT(a_done_is_last, !(out_valid_o && out_data_o.list_done) || out_data_o.last_of_run)

endmodule

FILE: test/brs_order_checker.sv
module brs_order_checker
  import brs_pkg::*;
#(
  parameter int MAX_GROUP = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_item_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_item_t        out_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  out_item_t                reordered_q[$];
  logic signed [DATA_W-1:0] group_words [MAX_GROUP];
  int                       fill;
  logic [CFG_W-1:0]         group_len;
  int                       fails = 0;
  int                       waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  function automatic out_item_t make_word(logic signed [DATA_W-1:0] v, logic last, logic done);
    out_item_t w;
    w.value_out   = v;
    w.last_of_run = last;
    w.list_done   = done;
    return w;
  endfunction

  task automatic predict_reorder(in_item_t item);
    int k;
    int n;
    k = (group_len > MAX_GROUP) ? MAX_GROUP : int'(group_len);
    if (fill > MAX_GROUP - 1) fill = MAX_GROUP - 1;
    if (k <= 1) begin
      // flush what is held in arrival order, then the new word
      for (int i = 0; i < fill; i++) reordered_q.push_back(make_word(group_words[i], 1'b0, 1'b0));
      reordered_q.push_back(make_word(item.value, 1'b1, item.end_of_list));
      fill = 0;
    end else begin
      group_words[fill] = item.value;
      n = fill + 1;
      if (n >= k) begin
        for (int i = n - 1; i >= 0; i--)
          reordered_q.push_back(make_word(group_words[i], i == 0, (i == 0) && item.end_of_list));
        fill = 0;
      end else if (item.end_of_list) begin
        for (int i = 0; i < n; i++)
          reordered_q.push_back(make_word(group_words[i], i == n - 1, i == n - 1));
        fill = 0;
      end else begin
        fill = n;
      end
    end
  endtask

  task automatic check_word(out_item_t got);
    out_item_t want;
    bit        bad;
    bad = 1'b0;
    if (reordered_q.size() == 0) begin
      $display("%0t unexpected output: expected none actual %h", $time, got);
      fails++;
    end else begin
      want = reordered_q.pop_front();
      if (got.value_out !== want.value_out) begin
        $display("%0t value_out: expected %h actual %h", $time, want.value_out, got.value_out);
        bad = 1'b1;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $display("%0t last_of_run: expected %b actual %b", $time, want.last_of_run,
                 got.last_of_run);
        bad = 1'b1;
      end
      if (got.list_done !== want.list_done) begin
        $display("%0t list_done: expected %b actual %b", $time, want.list_done, got.list_done);
        bad = 1'b1;
      end
      if (bad) fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reordered_q.delete();
      fill      = 0;
      group_len = BLOCK_SIZE_RESET;
      waiting   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_word(out_data_i);
      if (in_valid_i && !in_stall_i) predict_reorder(in_data_i);
      if (cfg_we_i) group_len = cfg_data_i;
      waiting = reordered_q.size();
    end
  end

endmodule

FILE: test/tb_block_reverse_stream_unit.sv
module tb_block_reverse_stream_unit;
  import brs_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT  = 1000;
  // settling time after the last expected word
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 20;
  // group lengths for the random phases: oversized, pass-through and full size among them
  localparam logic [CFG_W-1:0] PHASE_LEN [11] = '{
    5'd3, 5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd4, 5'd2, 5'd7, 5'd16, 5'd5
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;

  int fail_count;
  int words_pending;
  int quiet_cycles = 0;
  bit no_idle      = 1'b0;

  block_reverse_stream_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_item)
  );

  // watches both channels and the config port, keeps the expected word order
  brs_order_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk) begin
    out_stall = !no_idle && ($urandom_range(0, 99) < 24);
  end

  // hang detection: any transfer or config write restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // mostly random words, with the extremes mixed in often
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // offer one word and hold it until the transfer happens
  task automatic send_word(logic signed [DATA_W-1:0] v, logic eol);
    int gap;
    if (!no_idle && ($urandom_range(0, 99) < 24)) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid              = 1'b1;
    in_item.value         = v;
    in_item.end_of_list   = eol;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait until every expected word is out and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // group length change, only ever with the block idle
  task automatic set_group_len(logic [CFG_W-1:0] k);
    settle();
    cfg_we   = 1'b1;
    cfg_data = k;
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  initial begin
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset length of two: a full group closed by end of list, extremes as data
    send_word(32'sh7fffffff, 1'b0);
    send_word(32'sh80000000, 1'b1);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    // lone word flushed at end of list keeps its order
    send_word(pick_value(), 1'b1);

    // length lowered while the buffer already holds more than the new length
    set_group_len(5'd5);
    repeat (3) send_word(pick_value(), 1'b0);
    set_group_len(5'd2);
    send_word(pick_value(), 1'b0);

    // switch to pass-through with words still held
    set_group_len(5'd4);
    repeat (2) send_word(pick_value(), 1'b0);
    set_group_len(5'd0);
    send_word(pick_value(), 1'b0);
    set_group_len(5'd1);
    send_word(pick_value(), 1'b1);

    // oversized length behaves as the full buffer, partial group flushed
    set_group_len(5'd31);
    repeat (3) send_word(pick_value(), 1'b0);
    send_word(pick_value(), 1'b1);

    // random phases, one with no idling on either side
    for (int p = 0; p < 11; p++) begin
      no_idle = (p == 3);
      set_group_len(PHASE_LEN[p]);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        // occasional mid-list length change, taken while idle
        if ($urandom_range(0, 29) == 0) set_group_len(CFG_W'($urandom_range(0, 31)));
        send_word(pick_value(), $urandom_range(0, 11) == 0);
      end
    end
    no_idle = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
